// ===== hw/rtl/cmwr_pkg.sv =====
`timescale 1ns / 1ps
package cmwr_pkg;

  // Valid field ranges.
  localparam logic [13:0] YEAR_MIN  = 14'd1;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_MIN = 4'd1;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [2:0]  ROW_MAX   = 3'd5;
  localparam logic [3:0]  MONTH_FEB = 4'd2;

  // Reciprocal of 100: (x * DIV100_MUL) >> DIV100_SHIFT equals x / 100 for x < 43699.
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned PROD_W       = 27;
  localparam int unsigned QUOT_W       = PROD_W - DIV100_SHIFT;

  // Weekday of 1 January of year 1 (a Monday), consistent with 1 Jan 1970 on a Thursday.
  localparam logic [14:0] JAN1_BASE = 15'd1;

  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned SUM_W = 15;

  typedef logic [4:0] day_t;

  // Stage 1 result: range check and the quotient of (year - 1) by 100.
  typedef struct packed {
    logic              ok;
    logic [13:0]       prev_year;
    logic [QUOT_W-1:0] cent_q;
    logic [3:0]        month;
    logic [2:0]        row;
  } s1_t;

  // Stage 2 result: day count before the first of the month, reduced mod 7 later.
  typedef struct packed {
    logic             ok;
    logic [SUM_W-1:0] day_sum;
    day_t             len;
    logic [2:0]       row;
  } s2_t;

  // Stage 3 result: weekday of the first of the month.
  typedef struct packed {
    logic       ok;
    logic [2:0] first;
    day_t       len;
    logic [2:0] row;
  } s3_t;

  // Length of each month in a common year.
  function automatic day_t month_days(input logic [3:0] month);
    day_t d;
    case (month)
      4'd1:    d = 5'd31;
      4'd2:    d = 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/cmwr_div.sv =====
`timescale 1ns / 1ps
module cmwr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  logic [13:0]       year,
  input  logic [3:0]        month,
  input  logic [2:0]        week_row,
  output logic              vld_out,
  output cmwr_pkg::s1_t     s1_out
);

  logic                              vld_r;
  cmwr_pkg::s1_t                     s1_r;
  cmwr_pkg::s1_t                     s1_nxt;
  logic [13:0]                       prev_year;
  logic [cmwr_pkg::PROD_W-1:0]       prod;

  assign prev_year = year - 14'd1;
  assign prod = cmwr_pkg::PROD_W'(prev_year) *
                cmwr_pkg::PROD_W'(cmwr_pkg::DIV100_MUL);

  always_comb begin
    s1_nxt.ok = (year >= cmwr_pkg::YEAR_MIN) && (year <= cmwr_pkg::YEAR_MAX) &&
                (month >= cmwr_pkg::MONTH_MIN) && (month <= cmwr_pkg::MONTH_MAX) &&
                (week_row <= cmwr_pkg::ROW_MAX);
    s1_nxt.prev_year = prev_year;
    s1_nxt.cent_q    = prod[cmwr_pkg::PROD_W-1:cmwr_pkg::DIV100_SHIFT];
    s1_nxt.month     = month;
    s1_nxt.row       = week_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s1_out  = s1_r;

endmodule

// ===== hw/rtl/cmwr_leap.sv =====
`timescale 1ns / 1ps
module cmwr_leap (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  cmwr_pkg::s1_t s1_in,
  output logic          vld_out,
  output cmwr_pkg::s2_t s2_out
);

  logic          vld_r;
  cmwr_pkg::s2_t s2_r;
  cmwr_pkg::s2_t s2_nxt;
  logic [14:0]   q100;
  logic [14:0]   rem100;
  logic          is_cent;
  logic          is_leap;
  logic          feb_add;
  logic          after_feb;

  // The year is a multiple of 100 exactly when (year - 1) mod 100 is 99.
  assign q100    = 15'(s1_in.cent_q) * 15'd100;
  assign rem100  = {1'b0, s1_in.prev_year} - q100;
  assign is_cent = (rem100 == 15'd99);
  // Multiple of 400 when also (year - 1) / 100 is 3 mod 4.
  assign is_leap = is_cent ? (s1_in.cent_q[1:0] == 2'b11)
                           : (s1_in.prev_year[1:0] == 2'b11);
  assign feb_add   = is_leap && (s1_in.month == cmwr_pkg::MONTH_FEB);
  assign after_feb = is_leap && (s1_in.month > cmwr_pkg::MONTH_FEB);

  always_comb begin
    s2_nxt.ok  = s1_in.ok;
    s2_nxt.row = s1_in.row;
    s2_nxt.len = cmwr_pkg::month_days(s1_in.month) + cmwr_pkg::day_t'(feb_add);
    // 365 is 1 mod 7, so each prior year adds one weekday plus the leap days.
    s2_nxt.day_sum = cmwr_pkg::JAN1_BASE
                   + {1'b0, s1_in.prev_year}
                   + 15'(s1_in.prev_year >> 2)
                   - 15'(s1_in.cent_q)
                   + 15'(s1_in.cent_q >> 2)
                   + 15'(cmwr_pkg::days_before(s1_in.month))
                   + 15'(after_feb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s2_out  = s2_r;

endmodule

// ===== hw/rtl/cmwr_mod7.sv =====
`timescale 1ns / 1ps
module cmwr_mod7 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_in,
  input  cmwr_pkg::s2_t s2_in,
  output logic          vld_out,
  output cmwr_pkg::s3_t s3_out
);

  logic          vld_r;
  cmwr_pkg::s3_t s3_r;
  cmwr_pkg::s3_t s3_nxt;
  logic [5:0]    fold1;
  logic [3:0]    fold2;
  logic [3:0]    fold3;
  logic [3:0]    red;

  // Eight is 1 mod 7, so summing octal digits keeps the residue.
  assign fold1 = 6'(s2_in.day_sum[2:0]) + 6'(s2_in.day_sum[5:3]) +
                 6'(s2_in.day_sum[8:6]) + 6'(s2_in.day_sum[11:9]) +
                 6'(s2_in.day_sum[14:12]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
  assign fold3 = 4'(fold2[2:0]) + 4'(fold2[3]);
  assign red   = (fold3 >= 4'(cmwr_pkg::DAYS_PER_WEEK))
               ? fold3 - 4'(cmwr_pkg::DAYS_PER_WEEK) : fold3;

  always_comb begin
    s3_nxt.ok    = s2_in.ok;
    s3_nxt.first = red[2:0];
    s3_nxt.len   = s2_in.len;
    s3_nxt.row   = s2_in.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s3_out  = s3_r;

endmodule

// ===== hw/rtl/cmwr_cells.sv =====
`timescale 1ns / 1ps
module cmwr_cells (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  cmwr_pkg::s3_t  s3_in,
  output logic           vld_out,
  output cmwr_pkg::day_t day [cmwr_pkg::DAYS_PER_WEEK],
  output logic [2:0]     first_weekday,
  output cmwr_pkg::day_t month_length,
  output logic           in_range
);

  logic           vld_r;
  cmwr_pkg::day_t day_r   [cmwr_pkg::DAYS_PER_WEEK];
  cmwr_pkg::day_t day_nxt [cmwr_pkg::DAYS_PER_WEEK];
  logic [2:0]     first_r;
  cmwr_pkg::day_t len_r;
  logic           ok_r;
  logic [5:0]     row_base;

  assign row_base = 6'(s3_in.row) * 6'd7 + 6'd1;

  // Cell c holds 1 + 7*row + c - first when that lands within the month.
  always_comb begin
    for (int c = 0; c < cmwr_pkg::DAYS_PER_WEEK; c++) begin
      logic [5:0] pos;
      logic [5:0] d;
      pos = row_base + 6'(c);
      d   = pos - 6'(s3_in.first);
      if (s3_in.ok && (pos > 6'(s3_in.first)) && (d <= 6'(s3_in.len))) begin
        day_nxt[c] = d[4:0];
      end else begin
        day_nxt[c] = 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_r   <= day_nxt;
      first_r <= s3_in.ok ? s3_in.first : 3'd0;
      len_r   <= s3_in.ok ? s3_in.len : 5'd0;
      ok_r    <= s3_in.ok;
    end
  end

  assign vld_out       = vld_r;
  assign day           = day_r;
  assign first_weekday = first_r;
  assign month_length  = len_r;
  assign in_range      = ok_r;

endmodule

// ===== hw/rtl/calendar_month_week_row.sv =====
`timescale 1ns / 1ps
// Calendar row generator. Each request carries a proleptic Gregorian year, a month and a
// week row of a Sunday-first month grid; the result gives the seven dates of that row
// (0 for a blank cell), the weekday of the month's first day (0 is Sunday) and the month
// length, 29 for a leap February. A request with a year outside 1 to 9999, a month outside
// 1 to 12 or a row above 5 returns in_range low and every other field zero. The block is a
// four-stage pipeline: a range check with a reciprocal multiply for the division by 100,
// leap detection and closed-form day counting, a mod-7 reduction by octal digit folding,
// and the cell compare that feeds the output register. It takes one request per clock when
// no stall backs up the pipeline; a request passes the stage 1, 2 and 3 registers and the
// output register before its result is presented. Every stage holds its own valid bit, so
// a stall on the result side only stops stages that are full, and bubbles close up.
module calendar_month_week_row (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [2:0]  in_week_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day_sun,
  output logic [4:0]  out_day_mon,
  output logic [4:0]  out_day_tue,
  output logic [4:0]  out_day_wed,
  output logic [4:0]  out_day_thu,
  output logic [4:0]  out_day_fri,
  output logic [4:0]  out_day_sat,
  output logic [2:0]  out_first_weekday,
  output logic [4:0]  out_month_length,
  output logic        out_in_range
);

  logic           v1;
  logic           v2;
  logic           v3;
  logic           en1;
  logic           en2;
  logic           en3;
  logic           en4;
  cmwr_pkg::s1_t  s1;
  cmwr_pkg::s2_t  s2;
  cmwr_pkg::s3_t  s3;
  cmwr_pkg::day_t day [cmwr_pkg::DAYS_PER_WEEK];

  // A stage loads when it is empty or when its contents move on in the same cycle.
  assign en4      = !out_valid || !out_stall;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  cmwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en1),
    .vld_in   (in_valid),
    .year     (in_year),
    .month    (in_month),
    .week_row (in_week_row),
    .vld_out  (v1),
    .s1_out   (s1)
  );

  cmwr_leap u_leap (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en2),
    .vld_in  (v1),
    .s1_in   (s1),
    .vld_out (v2),
    .s2_out  (s2)
  );

  cmwr_mod7 u_mod7 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en3),
    .vld_in  (v2),
    .s2_in   (s2),
    .vld_out (v3),
    .s3_out  (s3)
  );

  cmwr_cells u_cells (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en4),
    .vld_in        (v3),
    .s3_in         (s3),
    .vld_out       (out_valid),
    .day           (day),
    .first_weekday (out_first_weekday),
    .month_length  (out_month_length),
    .in_range      (out_in_range)
  );

  // Cells are ordered Sunday first.
  assign out_day_sun = day[0];
  assign out_day_mon = day[1];
  assign out_day_tue = day[2];
  assign out_day_wed = day[3];
  assign out_day_thu = day[4];
  assign out_day_fri = day[5];
  assign out_day_sat = day[6];

endmodule
